// ===== rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned NUM_W      = 11;   // hue dividend before scaling, up to 7*255
    localparam int unsigned HUE_REM_W  = 19;   // 255 * num
    localparam int unsigned HUE_DIV_W  = 11;   // 6 * span
    localparam int unsigned SAT_REM_W  = 16;   // 255 * span
    localparam int unsigned SAT_DIV_W  = 8;    // max channel
    localparam int unsigned QUOT_W     = 9;    // hue quotient reaches 297 before wrap

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] span;
        max_sel_t          sel;
    } prep_t;

    typedef struct packed {
        logic [HUE_REM_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [QUOT_W-1:0]    hue_quot;
        logic [SAT_REM_W-1:0] sat_rem;
        logic [SAT_DIV_W-1:0] sat_div;
        logic [QUOT_W-1:0]    sat_quot;
        logic [CHAN_W-1:0]    brightness;
    } div_t;

endpackage

// ===== rtl/rgbhsv_prep.sv =====
module rgbhsv_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]       blue,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]       green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]       red,
    output logic                                dn_valid,
    input  logic                                dn_ready,
    output rgbhsv_pkg::prep_t                   dn_data
);

    logic              valid_reg;
    logic              valid_next;
    rgbhsv_pkg::prep_t data_reg;
    rgbhsv_pkg::prep_t data_next;
    logic [rgbhsv_pkg::CHAN_W-1:0] lo;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next       = data_reg;
        data_next.blue  = blue;
        data_next.green = green;
        data_next.red   = red;
        // priority red, then green, then blue on ties
        priority if (red >= green && red >= blue)
        begin
            data_next.sel = rgbhsv_pkg::SEL_RED;
            data_next.hi  = red;
        end
        else if (green >= blue)
        begin
            data_next.sel = rgbhsv_pkg::SEL_GREEN;
            data_next.hi  = green;
        end
        else
        begin
            data_next.sel = rgbhsv_pkg::SEL_BLUE;
            data_next.hi  = blue;
        end
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        data_next.span = data_next.hi - lo;
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/rgbhsv_scale.sv =====
module rgbhsv_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  rgbhsv_pkg::prep_t      up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output rgbhsv_pkg::div_t       dn_data
);

    logic             valid_reg;
    logic             valid_next;
    rgbhsv_pkg::div_t data_reg;
    rgbhsv_pkg::div_t data_next;
    logic [rgbhsv_pkg::NUM_W-1:0]     num;
    logic [rgbhsv_pkg::NUM_W-1:0]     span_w;
    logic [rgbhsv_pkg::HUE_DIV_W-1:0] span6;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        span_w = rgbhsv_pkg::NUM_W'(up_data.span);
        span6  = rgbhsv_pkg::HUE_DIV_W'((span_w << 2) + (span_w << 1));
        unique case (up_data.sel)
            rgbhsv_pkg::SEL_RED:
                num = rgbhsv_pkg::NUM_W'(up_data.green) + span6
                      - rgbhsv_pkg::NUM_W'(up_data.blue);
            rgbhsv_pkg::SEL_GREEN:
                num = rgbhsv_pkg::NUM_W'(up_data.blue) + (span_w << 1)
                      - rgbhsv_pkg::NUM_W'(up_data.red);
            default:
                num = rgbhsv_pkg::NUM_W'(up_data.red) + (span_w << 2)
                      - rgbhsv_pkg::NUM_W'(up_data.green);
        endcase

        // x*255 = (x << 8) - x; a zero divisor is forced to 1 so the
        // zero dividend (grey or black pixel) yields a zero quotient
        data_next.hue_rem  = (rgbhsv_pkg::HUE_REM_W'(num) << 8)
                             - rgbhsv_pkg::HUE_REM_W'(num);
        data_next.hue_div  = {span6[rgbhsv_pkg::HUE_DIV_W-1:1],
                              span6[0] | (up_data.span == '0)};
        data_next.hue_quot = '0;
        data_next.sat_rem  = (rgbhsv_pkg::SAT_REM_W'(up_data.span) << 8)
                             - rgbhsv_pkg::SAT_REM_W'(up_data.span);
        data_next.sat_div  = {up_data.hi[rgbhsv_pkg::SAT_DIV_W-1:1],
                              up_data.hi[0] | (up_data.hi == '0)};
        data_next.sat_quot = '0;
        data_next.brightness = up_data.hi;
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/rgbhsv_div_cell.sv =====
// One restoring-division step for both the hue and saturation quotients.
module rgbhsv_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  rgbhsv_pkg::div_t       up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output rgbhsv_pkg::div_t       dn_data
);

    localparam int unsigned HW = rgbhsv_pkg::HUE_REM_W + 1;
    localparam int unsigned SW = rgbhsv_pkg::SAT_REM_W + 1;

    logic             valid_reg;
    logic             valid_next;
    rgbhsv_pkg::div_t data_reg;
    rgbhsv_pkg::div_t data_next;
    logic [HW-1:0]    hue_sub;
    logic [HW-1:0]    hue_rem_w;
    logic [SW-1:0]    sat_sub;
    logic [SW-1:0]    sat_rem_w;
    logic             hue_bit;
    logic             sat_bit;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        hue_sub   = HW'(up_data.hue_div) << SHIFT;
        hue_rem_w = HW'(up_data.hue_rem);
        hue_bit   = hue_rem_w >= hue_sub;
        sat_sub   = SW'(up_data.sat_div) << SHIFT;
        sat_rem_w = SW'(up_data.sat_rem);
        sat_bit   = sat_rem_w >= sat_sub;

        data_next          = up_data;
        data_next.hue_rem  = hue_bit ? rgbhsv_pkg::HUE_REM_W'(hue_rem_w - hue_sub)
                                     : up_data.hue_rem;
        data_next.hue_quot = {up_data.hue_quot[rgbhsv_pkg::QUOT_W-2:0], hue_bit};
        data_next.sat_rem  = sat_bit ? rgbhsv_pkg::SAT_REM_W'(sat_rem_w - sat_sub)
                                     : up_data.sat_rem;
        data_next.sat_quot = {up_data.sat_quot[rgbhsv_pkg::QUOT_W-2:0], sat_bit};
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== rtl/rgb_to_hsv_pixel_core.sv =====
// Stages: 11 register stages (2 front stages plus one per quotient bit through
// 9 division cells); hsv_valid comes from the last cell's valid register.
// Throughput: one item per cycle while hsv_ready is high; every stage advances whenever its
// successor is empty or being drained, so stalls back up stage by stage.
// Reset: rst_n clears all stage valid flags asynchronously; data is unreset.
module rgb_to_hsv_pixel_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     blue,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     green,
    input  logic [rgbhsv_pkg::CHAN_W-1:0]     red,
    output logic                              hsv_valid,
    input  logic                              hsv_ready,
    output logic [rgbhsv_pkg::CHAN_W-1:0]     hue,
    output logic [rgbhsv_pkg::CHAN_W-1:0]     saturation,
    output logic [rgbhsv_pkg::CHAN_W-1:0]     brightness
);

    localparam int unsigned NCELL = rgbhsv_pkg::QUOT_W;

    logic              prep_valid;
    logic              prep_ready;
    rgbhsv_pkg::prep_t prep_data;

    logic             chain_valid [NCELL+1];
    logic             chain_ready [NCELL+1];
    rgbhsv_pkg::div_t chain_data  [NCELL+1];

    rgbhsv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_ready (pixel_ready),
        .blue     (blue),
        .green    (green),
        .red      (red),
        .dn_valid (prep_valid),
        .dn_ready (prep_ready),
        .dn_data  (prep_data)
    );

    rgbhsv_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prep_valid),
        .up_ready (prep_ready),
        .up_data  (prep_data),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_data  (chain_data[0])
    );

    // quotient bits are resolved MSB first, one per cell
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rgbhsv_div_cell #(
            .SHIFT (NCELL - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[k]),
            .up_ready (chain_ready[k]),
            .up_data  (chain_data[k]),
            .dn_valid (chain_valid[k+1]),
            .dn_ready (chain_ready[k+1]),
            .dn_data  (chain_data[k+1])
        );
    end

    assign hsv_valid          = chain_valid[NCELL];
    assign chain_ready[NCELL] = hsv_ready;
    // hue wraps mod 256
    assign hue        = chain_data[NCELL].hue_quot[rgbhsv_pkg::CHAN_W-1:0];
    assign saturation = chain_data[NCELL].sat_quot[rgbhsv_pkg::CHAN_W-1:0];
    assign brightness = chain_data[NCELL].brightness;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    localparam int unsigned CLK_HALF    = 10;
    localparam int unsigned RESET_CYC   = 11;
    localparam int unsigned PIPE_LAT    = 11;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYC    = 150;

    typedef logic [rgbhsv_pkg::CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t hue;
        chan_t saturation;
        chan_t brightness;
    } hsv_t;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  pixel_valid = 1'b0;
    logic  pixel_ready;
    chan_t blue        = '0;
    chan_t green       = '0;
    chan_t red         = '0;
    logic  hsv_valid;
    logic  hsv_ready   = 1'b0;
    chan_t hue;
    chan_t saturation;
    chan_t brightness;

    hsv_t        hsv_expected[$];
    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 49;
    int unsigned errors        = 0;
    int unsigned pixels_sent   = 0;
    int unsigned pixels_seen   = 0;
    int unsigned input_stalls  = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_left     = 0;
    logic        hold_toggle   = 1'b0;
    logic        hold_seen     = 1'b0;

    rgb_to_hsv_pixel_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .hsv_valid   (hsv_valid),
        .hsv_ready   (hsv_ready),
        .hue         (hue),
        .saturation  (saturation),
        .brightness  (brightness)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic hsv_t predict_hsv(chan_t b, chan_t g, chan_t r);
        int unsigned          bb;
        int unsigned          gg;
        int unsigned          rr;
        int unsigned          hi;
        int unsigned          lo;
        int unsigned          span;
        int unsigned          num;
        int unsigned          quot;
        rgbhsv_pkg::max_sel_t sel;
        hsv_t                 res;
        bb = 32'(b);
        gg = 32'(g);
        rr = 32'(r);
        hi = rr;
        sel = rgbhsv_pkg::SEL_RED;
        if (gg > hi)
        begin
            hi = gg;
            sel = rgbhsv_pkg::SEL_GREEN;
        end
        if (bb > hi)
        begin
            hi = bb;
            sel = rgbhsv_pkg::SEL_BLUE;
        end
        lo = rr;
        if (gg < lo)
            lo = gg;
        if (bb < lo)
            lo = bb;
        span = hi - lo;
        res = '0;
        res.brightness = hi[rgbhsv_pkg::CHAN_W-1:0];
        if (span != 0)
        begin
            case (sel)
                rgbhsv_pkg::SEL_RED:   num = gg + 6 * span - bb;
                rgbhsv_pkg::SEL_GREEN: num = bb + 2 * span - rr;
                default:               num = rr + 4 * span - gg;
            endcase
            // red-dominant hues above 255 wrap back to the bottom of the circle
            quot = (255 * num) / (6 * span);
            res.hue = quot[rgbhsv_pkg::CHAN_W-1:0];
        end
        if (hi != 0)
        begin
            quot = (255 * span) / hi;
            res.saturation = quot[rgbhsv_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    // one item per call; valid stays high across back-to-back calls unless the next call inserts random idle gaps
    task automatic send_pixel(chan_t b, chan_t g, chan_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        blue  <= b;
        green <= g;
        red   <= r;
        hsv_expected.push_back(predict_hsv(b, g, r));
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    function automatic chan_t pick_edge_value();
        case ($urandom_range(4))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd1;
            3: return 8'd254;
            default: return chan_t'($urandom);
        endcase
    endfunction

    task automatic send_random_pixel();
        chan_t b;
        chan_t g;
        chan_t r;
        chan_t base;
        b = chan_t'($urandom);
        g = chan_t'($urandom);
        r = chan_t'($urandom);
        case ($urandom_range(9))
            6:
            begin
                // near grey: tiny span stresses the divider
                base = chan_t'($urandom_range(250, 2));
                b = base + chan_t'($urandom_range(2)) - 8'd1;
                g = base + chan_t'($urandom_range(2)) - 8'd1;
                r = base + chan_t'($urandom_range(2)) - 8'd1;
            end
            7:
            begin
                case ($urandom_range(2))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            8:
            begin
                // red on top, green above blue
                r = chan_t'($urandom_range(255, 2));
                g = chan_t'($urandom_range(32'(r) - 32'd1, 1));
                b = chan_t'($urandom_range(32'(g) - 32'd1, 0));
            end
            9:
            begin
                b = pick_edge_value();
                g = pick_edge_value();
                r = pick_edge_value();
            end
            default: ;
        endcase
        send_pixel(b, g, r);
    endtask

    task automatic test_extremes();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd1);
        send_pixel(8'd170, 8'd85,  8'd0);
    endtask

    task automatic test_ties();
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd10,  8'd200, 8'd200);
        send_pixel(8'd200, 8'd200, 8'd10);
        send_pixel(8'd200, 8'd10,  8'd200);
    endtask

    task automatic test_hue_wrap();
        send_pixel(8'd0,   8'd1,   8'd255);
        send_pixel(8'd0,   8'd254, 8'd255);
        send_pixel(8'd50,  8'd120, 8'd200);
        send_pixel(8'd120, 8'd50,  8'd200);
        send_pixel(8'd0,   8'd1,   8'd2);
    endtask

    task automatic test_random_phase(int unsigned count, int unsigned s_pct, int unsigned r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_random_pixel();
    endtask

    // receiver stops for a long stretch while items keep coming
    task automatic test_backpressure(int unsigned count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        pixel_valid <= 1'b0;
        hold_toggle = ~hold_toggle;
        repeat (count)
            send_random_pixel();
    endtask

    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYC;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            hsv_ready <= 1'b0;
        end
        else
            hsv_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        hsv_t want;
        cycle_count++;
        if (rst_n && pixel_valid && !pixel_ready)
            input_stalls++;
        if (rst_n && hsv_valid === 1'b1 && hsv_ready)
        begin
            if (hsv_expected.size() == 0)
            begin
                $error("unexpected item: hue %0d saturation %0d brightness %0d",
                       hue, saturation, brightness);
                errors++;
            end
            else
            begin
                want = hsv_expected.pop_front();
                pixels_seen++;
                if (hue !== want.hue)
                begin
                    $error("hue: expected %0d, got %0d", want.hue, hue);
                    errors++;
                end
                if (saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, got %0d", want.saturation, saturation);
                    errors++;
                end
                if (brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, got %0d", want.brightness, brightness);
                    errors++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding",
                     cycle_count, hsv_expected.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYC)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_ties();
        test_hue_wrap();
        test_random_phase(400, 30, 49);
        test_random_phase(400, 49, 30);
        test_random_phase(350, 0, 0);
        test_backpressure(100);

        @(negedge clk);
        pixel_valid <= 1'b0;
        while (hsv_expected.size() != 0)
            @(posedge clk);
        repeat (3 * PIPE_LAT)
            @(posedge clk);

        $display("covered %0d pixels (%0d checked): extremes, ties, hue wrap, random",
                 pixels_sent, pixels_seen);
        $display("idle mixes and a %0d-cycle output hold; input stalled %0d cycles",
                 HOLD_CYC, input_stalls);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
